>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL; stq_seq includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while in reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property that must hold at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/stq_pkg.sv
// ---------------------------------------------------------------------------
// stq_pkg
// Types, constants and codes of the sorted timer queue.
// ---------------------------------------------------------------------------
package stq_pkg;

	localparam int DEPTH     = 128;
	localparam int TIME_BITS = 48;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int CMP_W     = (CNT_W > 8) ? CNT_W : 8;
	localparam int SLEEP_W   = 42;
	localparam int PROD_W    = 42;

	localparam logic [9:0]         US_PER_MS      = 10'd1000;
	localparam logic [SLEEP_W-1:0] EMPTY_SLEEP_US = SLEEP_W'(2000000);
	localparam logic [63:0]        SLEEP_MAX      = (64'd1 << SLEEP_W) - 64'd1;
	localparam logic [7:0]         MAX_RESET      = 8'd100;

	localparam logic REG_MAX_ENTRIES = 1'b0;

	localparam logic [2:0] ACT_ADD    = 3'd0;
	localparam logic [2:0] ACT_DEL    = 3'd1;
	localparam logic [2:0] ACT_SET    = 3'd2;
	localparam logic [2:0] ACT_PULL   = 3'd3;
	localparam logic [2:0] ACT_EXISTS = 3'd4;

	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_ERR      = 3'd1;
	localparam logic [2:0] STAT_NOTFOUND = 3'd2;
	localparam logic [2:0] STAT_DUE      = 3'd3;
	localparam logic [2:0] STAT_NONE     = 3'd4;

	typedef struct packed {
		logic [2:0]           action;
		logic [30:0]          timer_id;
		logic [31:0]          timeout_ms;
		logic                 cyclic;
		logic [31:0]          cmd_tag;
		logic [31:0]          param_tag;
		logic [15:0]          param_size;
		logic [TIME_BITS-1:0] now_us;
	} stq_in_t;

	typedef struct packed {
		logic [2:0]         status;
		logic               found;
		logic [30:0]        due_timer_id;
		logic [31:0]        due_cmd_tag;
		logic [31:0]        due_param_tag;
		logic [15:0]        due_param_size;
		logic               due_cyclic;
		logic [SLEEP_W-1:0] sleep_us;
	} stq_out_t;

	typedef struct packed {
		logic [30:0]          id;
		logic [TIME_BITS-1:0] expiry;
		logic [31:0]          interval;
		logic                 cyclic;
		logic [31:0]          cmd;
		logic [31:0]          param;
		logic [15:0]          len;
	} stq_ent_t;

	typedef struct packed {
		logic busy;
		logic done;
	} stq_stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND_RD,
		S_FIND_CHK,
		S_RM_RD,
		S_RM_CHK,
		S_ARM_MUL,
		S_ARM_ADD,
		S_INS_RD,
		S_INS_CHK,
		S_HEAD_RD,
		S_HEAD_CHK,
		S_DONE
	} stq_state_t;

endpackage

>>> hw/rtl/sorted_timer_queue_core.sv
// ---------------------------------------------------------------------------
// sorted_timer_queue_core
// Sorted timer table with command port, result strobe and APB register.
// ---------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; its result word
// appears on result for exactly one cycle with done high and must be captured
// then, as the block cannot be stalled. Timers sit in one entry RAM sorted by
// expiry; each table step is a RAM read state followed by a check state that
// compares and, while shifting, writes. Id lookup scans entries from the head,
// removal shifts the later entries up, insertion shifts the later ones down
// from the tail; an empty pull, an add to a full table or an unknown action
// goes straight to the result. No clearing pass is needed after reset.
module sorted_timer_queue_core import stq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  stq_in_t     cmd,
	output logic        done,
	output stq_out_t    result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] max_q;
	stq_stat_t  stat;
	logic       reg_sel;

	// one register; byte address bits below the word are ignored
	assign reg_sel = (paddr[2] == REG_MAX_ENTRIES);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {24'd0, max_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			max_q <= pwdata[7:0];
		end
	end

	stq_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.max_entries (max_q),
		.stat        (stat),
		.result      (result)
	);

	assign busy = stat.busy;
	assign done = stat.done;

endmodule

>>> hw/rtl/stq_ram.sv
// ---------------------------------------------------------------------------
// stq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module stq_ram #(
	parameter int WIDTH = 8,
	parameter int WORDS = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(WORDS)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(WORDS)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/stq_seq.sv
// ---------------------------------------------------------------------------
// stq_seq
// Command sequencer: scans, shifts and inserts entries in the entry RAM.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stq_seq import stq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  stq_in_t   cmd,
	input  logic [7:0] max_entries,
	output stq_stat_t stat,
	output stq_out_t  result
);

	stq_state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	stq_in_t          cmd_q;
	stq_ent_t         ent_q;
	stq_out_t         res_q;
	stq_out_t         res_init;
	logic [PROD_W-1:0] prod_q;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	stq_ent_t         mem_wdata, rdata;

	logic [CNT_W-1:0] idx_inc, idx_dec;
	logic [TIME_BITS-1:0] diff;
	logic last_find, rm_last, id_hit, ins_move, head_due, full, accept;

	stq_ram #(.WIDTH($bits(stq_ent_t)), .WORDS(DEPTH)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	assign accept    = start && (state_q == S_IDLE);
	assign idx_inc   = idx_q + CNT_W'(1);
	assign idx_dec   = idx_q - CNT_W'(1);
	assign last_find = (idx_q == count_q);
	assign rm_last   = (idx_inc == count_q);
	assign id_hit    = (rdata.id == cmd_q.timer_id);
	assign ins_move  = (rdata.expiry > ent_q.expiry);
	assign head_due  = (cmd_q.now_us >= rdata.expiry);
	assign diff      = rdata.expiry - cmd_q.now_us;
	assign full      = (count_q == CNT_W'(DEPTH)) ||
	                   ((count_q != '0) && (CMP_W'(count_q) >= CMP_W'(max_entries)));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (cmd.action)
						ACT_ADD:                     state_d = full ? S_DONE : S_FIND_RD;
						ACT_DEL, ACT_SET, ACT_EXISTS: state_d = S_FIND_RD;
						ACT_PULL:                    state_d = (count_q == '0) ? S_DONE : S_HEAD_RD;
						default:                     state_d = S_DONE;
					endcase
				end
			end
			S_FIND_RD: begin
				if (!last_find) state_d = S_FIND_CHK;
				else if (cmd_q.action == ACT_ADD) state_d = S_ARM_MUL;
				else state_d = S_DONE;
			end
			S_FIND_CHK: begin
				if (!id_hit) state_d = S_FIND_RD;
				else if (cmd_q.action inside {ACT_DEL, ACT_SET}) state_d = S_RM_RD;
				else state_d = S_DONE;
			end
			S_RM_RD: begin
				if (!rm_last) state_d = S_RM_CHK;
				else if (cmd_q.action == ACT_SET) state_d = S_ARM_MUL;
				else if (cmd_q.action == ACT_PULL && ent_q.cyclic) state_d = S_ARM_MUL;
				else state_d = S_DONE;
			end
			S_RM_CHK:   state_d = S_RM_RD;
			S_ARM_MUL:  state_d = S_ARM_ADD;
			S_ARM_ADD:  state_d = S_INS_RD;
			S_INS_RD:   state_d = (idx_q == '0) ? S_DONE : S_INS_CHK;
			S_INS_CHK:  state_d = ins_move ? S_INS_RD : S_DONE;
			S_HEAD_RD:  state_d = S_HEAD_CHK;
			S_HEAD_CHK: state_d = head_due ? S_RM_RD : S_DONE;
			S_DONE:     state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// RAM access and status
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[IDX_W-1:0];
		mem_wdata = rdata;
		mem_raddr = idx_q[IDX_W-1:0];
		stat.busy = (state_q != S_IDLE);
		stat.done = (state_q == S_DONE);
		case (state_q)
			S_RM_RD:   mem_raddr = idx_inc[IDX_W-1:0];
			S_RM_CHK:  mem_we = 1'b1;
			S_INS_RD: begin
				mem_raddr = idx_dec[IDX_W-1:0];
				if (idx_q == '0) begin
					mem_we    = 1'b1;
					mem_wdata = ent_q;
				end
			end
			S_INS_CHK: begin
				mem_we = 1'b1;
				if (!ins_move) mem_wdata = ent_q;
			end
			S_HEAD_RD: mem_raddr = '0;
			default: ;
		endcase
	end

	// result word as it stands right after accept
	always_comb begin
		res_init = '0;
		case (cmd.action)
			ACT_ADD:                     res_init.status = full ? STAT_ERR : STAT_OK;
			ACT_DEL, ACT_SET, ACT_EXISTS: res_init.status = STAT_OK;
			ACT_PULL: begin
				if (count_q == '0) begin
					res_init.status   = STAT_NONE;
					res_init.sleep_us = EMPTY_SLEEP_US;
				end
			end
			default: res_init.status = STAT_ERR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE:     if (start) idx_q <= '0;
				S_FIND_CHK: if (!id_hit) idx_q <= idx_inc;
				S_RM_RD:    if (rm_last) count_q <= count_q - CNT_W'(1);
				S_RM_CHK:   idx_q <= idx_inc;
				S_ARM_ADD:  idx_q <= count_q;
				S_INS_RD:   if (idx_q == '0) count_q <= count_q + CNT_W'(1);
				S_INS_CHK: begin
					if (ins_move) idx_q <= idx_dec;
					else count_q <= count_q + CNT_W'(1);
				end
				S_HEAD_CHK: idx_q <= '0;
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q          <= cmd;
					res_q          <= res_init;
					ent_q.id       <= cmd.timer_id;
					ent_q.expiry   <= '0;
					ent_q.interval <= cmd.timeout_ms;
					ent_q.cyclic   <= cmd.cyclic;
					ent_q.cmd      <= cmd.cmd_tag;
					ent_q.param    <= cmd.param_tag;
					ent_q.len      <= cmd.param_size;
				end
			end
			S_FIND_RD: begin
				if (last_find && cmd_q.action == ACT_SET) res_q.status <= STAT_NOTFOUND;
			end
			S_FIND_CHK: begin
				if (id_hit && cmd_q.action == ACT_ADD) res_q.status <= STAT_ERR;
				if (id_hit && cmd_q.action == ACT_EXISTS) res_q.found <= 1'b1;
			end
			S_ARM_MUL: prod_q <= PROD_W'(ent_q.interval) * PROD_W'(US_PER_MS);
			S_ARM_ADD: ent_q.expiry <= TIME_BITS'(64'(cmd_q.now_us) + 64'(prod_q));
			S_HEAD_CHK: begin
				if (head_due) begin
					ent_q                <= rdata;
					res_q.status         <= STAT_DUE;
					res_q.due_timer_id   <= rdata.id;
					res_q.due_cmd_tag    <= rdata.cmd;
					res_q.due_param_tag  <= rdata.param;
					res_q.due_param_size <= rdata.len;
					res_q.due_cyclic     <= rdata.cyclic;
				end else begin
					res_q.status   <= STAT_NONE;
					res_q.sleep_us <= (64'(diff) > SLEEP_MAX) ? SLEEP_W'(SLEEP_MAX)
					                                          : SLEEP_W'(diff);
				end
			end
			default: ;
		endcase
	end

	assign result = res_q;

	`ASSERT_ALWAYS(a_count_range, count_q <= CNT_W'(DEPTH), "entry count above depth")
	`ASSERT_CLK(a_done_pulse, stat.done |=> !stat.done, "done held longer than one cycle")
	`ASSERT_CLK(a_wr_in_range, mem_we |-> (CNT_W'(mem_waddr) <= count_q), "write past table end")
	`ASSERT_CLK(a_accept_busy, accept |=> stat.busy, "accepted word did not raise busy")

endmodule

>>> tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted timer queue core: command words go in
// through the start/busy handshake, a predictor keeps its own copy of the
// timer table and every result word is checked against it in order.
// ---------------------------------------------------------------------------
module testbench import stq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	class timer_table_sb;
		stq_ent_t   timers[$];
		stq_out_t   pending[$];
		logic [7:0] max_timers = MAX_RESET;
		int         mismatches = 0;

		function int find_timer(logic [30:0] id);
			foreach (timers[i])
				if (timers[i].id == id) return i;
			return -1;
		endfunction

		function void arm(stq_ent_t e, logic [TIME_BITS-1:0] now);
			logic [63:0] span;
			int p;
			span = 64'(e.interval) * 64'd1000;
			e.expiry = TIME_BITS'(64'(now) + span);
			p = 0;
			while (p < timers.size() && timers[p].expiry <= e.expiry) p++;
			timers.insert(p, e);
		endfunction

		// compute the result word a command causes and queue it
		function void note_cmd(stq_in_t c);
			stq_out_t r;
			stq_ent_t e;
			stq_ent_t h;
			logic [TIME_BITS-1:0] d;
			int pos;
			r = '0;
			r.status = STAT_OK;
			e = '0;
			e.id = c.timer_id;
			e.interval = c.timeout_ms;
			e.cyclic = c.cyclic;
			e.cmd = c.cmd_tag;
			e.param = c.param_tag;
			e.len = c.param_size;
			pos = find_timer(c.timer_id);
			case (c.action)
				ACT_ADD: begin
					if (pos >= 0 || timers.size() >= DEPTH ||
					    (timers.size() != 0 && timers.size() >= max_timers))
						r.status = STAT_ERR;
					else
						arm(e, c.now_us);
				end
				ACT_DEL: begin
					if (pos >= 0) timers.delete(pos);
				end
				ACT_SET: begin
					if (pos < 0) begin
						r.status = STAT_NOTFOUND;
					end else begin
						timers.delete(pos);
						arm(e, c.now_us);
					end
				end
				ACT_PULL: begin
					if (timers.size() == 0) begin
						r.status = STAT_NONE;
						r.sleep_us = EMPTY_SLEEP_US;
					end else if (c.now_us >= timers[0].expiry) begin
						h = timers[0];
						r.status = STAT_DUE;
						r.due_timer_id = h.id;
						r.due_cmd_tag = h.cmd;
						r.due_param_tag = h.param;
						r.due_param_size = h.len;
						r.due_cyclic = h.cyclic;
						timers.delete(0);
						if (h.cyclic) arm(h, c.now_us);
					end else begin
						d = timers[0].expiry - c.now_us;
						r.status = STAT_NONE;
						r.sleep_us = (64'(d) > SLEEP_MAX) ? SLEEP_MAX[SLEEP_W-1:0] : SLEEP_W'(d);
					end
				end
				ACT_EXISTS: r.found = (pos >= 0);
				default: r.status = STAT_ERR;
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(stq_out_t got);
			stq_out_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) $display("result mismatch: expected %p got %p", want, got);
			end
		endfunction
	endclass

	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	stq_in_t     cmd;
	logic        done;
	stq_out_t    result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	timer_table_sb sb;
	int idle_cycles;
	int sent;
	int idle_pct;
	int id_pool;
	logic [TIME_BITS-1:0] clock_us;

	sorted_timer_queue_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(result);
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// register write followed by a read-back
	task automatic reg_write(logic [7:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= 3'(REG_MAX_ENTRIES) << 2; pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0; penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[7:0] !== val) begin
			sb.mismatches++;
			if (sb.mismatches <= 10)
				$display("max_entries read-back: expected %0d got %0d", val, prdata[7:0]);
		end
		psel <= 1'b0; penable <= 1'b0;
		sb.max_timers = val;
	endtask

	task automatic send_word(stq_in_t c);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		sb.note_cmd(c);
		sent++;
		idle_pct = (sent < 383) ? 21 : (sent < 766) ? 58 : 0;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic stq_in_t make_word(logic [2:0] act, logic [30:0] id,
	                                      logic [31:0] iv, logic cyc,
	                                      logic [TIME_BITS-1:0] now, logic ones);
		stq_in_t c;
		c.action = act;
		c.timer_id = id;
		c.timeout_ms = iv;
		c.cyclic = cyc;
		c.cmd_tag = ones ? '1 : '0;
		c.param_tag = ones ? '1 : '0;
		c.param_size = ones ? '1 : '0;
		c.now_us = now;
		return c;
	endfunction

	function automatic stq_in_t random_word();
		stq_in_t c;
		int pick;
		pick = $urandom_range(0, 99);
		c.action = (pick < 35) ? ACT_ADD : (pick < 45) ? ACT_DEL : (pick < 60) ? ACT_SET :
		           (pick < 86) ? ACT_PULL : (pick < 96) ? ACT_EXISTS :
		           3'($urandom_range(5, 7));
		pick = $urandom_range(0, 99);
		c.timer_id = (pick < 90) ? 31'($urandom_range(0, id_pool - 1)) :
		             (pick < 95) ? 31'h7FFF_FFFF - 31'($urandom_range(0, 3)) : 31'($urandom);
		pick = $urandom_range(0, 99);
		c.timeout_ms = (pick < 70) ? 32'($urandom_range(0, 5)) :
		               (pick < 90) ? 32'($urandom_range(0, 100)) : 32'($urandom);
		c.cyclic = 1'($urandom);
		c.cmd_tag = $urandom;
		c.param_tag = $urandom;
		c.param_size = 16'($urandom);
		pick = $urandom_range(0, 99);
		// time mostly moves forward, now and then jumps back or anywhere
		if (pick < 3)
			clock_us = clock_us - TIME_BITS'($urandom_range(0, 100000));
		else if (pick < 5)
			clock_us = {16'($urandom), 32'($urandom)};
		else
			clock_us = clock_us + TIME_BITS'($urandom_range(0, 3000));
		c.now_us = clock_us;
		return c;
	endfunction

	initial begin
		logic [7:0] limits [7];
		sb = new();
		limits = '{100, 1, 0, 128, 255, 7, 40};
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		idle_cycles = 0;
		sent = 0;
		idle_pct = 21;
		id_pool = 16;
		clock_us = 48'd1000;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		reg_write(8'd3);

		send_word(make_word(ACT_PULL, 31'd0, 32'd0, 1'b0, 48'd1000, 1'b0));
		send_word(make_word(ACT_EXISTS, 31'd0, 32'd0, 1'b0, 48'd1000, 1'b0));
		send_word(make_word(ACT_ADD, 31'd0, 32'd0, 1'b0, 48'd1000, 1'b1));
		send_word(make_word(ACT_ADD, 31'h7FFF_FFFF, 32'd2, 1'b1, 48'd1000, 1'b0));
		send_word(make_word(ACT_ADD, 31'd0, 32'd9, 1'b0, 48'd1000, 1'b0)); // duplicate
		send_word(make_word(ACT_ADD, 31'd5, 32'd2, 1'b0, 48'd1000, 1'b1)); // equal expiry
		send_word(make_word(ACT_ADD, 31'd6, 32'd1, 1'b0, 48'd1000, 1'b0)); // table full
		send_word(make_word(ACT_EXISTS, 31'h7FFF_FFFF, 32'd0, 1'b0, 48'd1000, 1'b1));
		send_word(make_word(ACT_PULL, 31'd0, 32'd0, 1'b0, 48'd1000, 1'b0));
		send_word(make_word(ACT_PULL, 31'd0, 32'd0, 1'b0, 48'd1000, 1'b0));
		send_word(make_word(ACT_SET, 31'd9, 32'd1, 1'b0, 48'd1000, 1'b0));
		send_word(make_word(ACT_SET, 31'd5, 32'd0, 1'b1, 48'd1500, 1'b1));
		send_word(make_word(ACT_DEL, 31'd77, 32'd0, 1'b0, 48'd1500, 1'b0));
		send_word(make_word(3'd5, 31'd0, 32'd0, 1'b0, 48'd1500, 1'b0));
		send_word(make_word(3'd6, 31'd0, 32'd0, 1'b0, 48'd1500, 1'b0));
		send_word(make_word(3'd7, 31'h7FFF_FFFF, '1, 1'b1, '1, 1'b1));
		send_word(make_word(ACT_PULL, 31'd0, 32'd0, 1'b0, 48'd6000, 1'b0));
		send_word(make_word(ACT_PULL, 31'd0, 32'd0, 1'b0, 48'd6000, 1'b0));
		send_word(make_word(ACT_DEL, 31'h7FFF_FFFF, 32'd0, 1'b0, 48'd6000, 1'b0));
		send_word(make_word(ACT_DEL, 31'd5, 32'd0, 1'b0, 48'd6000, 1'b0));
		// expiry wraps past the top of the time range
		send_word(make_word(ACT_ADD, 31'd1, 32'd1, 1'b0, '1, 1'b1));
		send_word(make_word(ACT_PULL, 31'd0, 32'd0, 1'b0, 48'd2000, 1'b0));
		// clock going backward: sleep saturates
		send_word(make_word(ACT_ADD, 31'd2, '1, 1'b0, 48'h8000_0000_0000, 1'b0));
		send_word(make_word(ACT_PULL, 31'd0, 32'd0, 1'b0, 48'd0, 1'b0));
		send_word(make_word(ACT_DEL, 31'd2, 32'd0, 1'b0, 48'd0, 1'b0));

		foreach (limits[k]) begin
			drain();
			reg_write(limits[k]);
			id_pool = (limits[k] > 127) ? 200 : 16;
			repeat (160) send_word(random_word());
		end
		drain();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/stq_pkg.sv
hw/rtl/stq_ram.sv
hw/rtl/stq_seq.sv
hw/rtl/sorted_timer_queue_core.sv
tb/testbench.sv
